// ===== hw/rtl/sbeq_pkg.sv =====
// Shared types and constants for the stereo biquad cascade equalizer.
// No dependencies; imported by stereo_biquad_cascade_eq and tb_top.
package sbeq_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int COEFF_BITS  = 32;
  localparam int GAIN_BITS   = 16;
  localparam int GAIN_FRAC   = 12;
  localparam int FRAC_BITS   = COEFF_BITS - 3;
  localparam int ACC_W       = COEFF_BITS + SAMPLE_BITS + 3;
  localparam int CNT_W       = 5;

  typedef enum logic [1:0] {
    OP_FRAME = 2'd0,
    OP_COEFF = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    REG_ENABLE = 2'd0,
    REG_MASK   = 2'd1,
    REG_GAIN   = 2'd2,
    REG_NONE   = 2'd3
  } reg_index_t;

  localparam logic [2:0] SLOT_LIMIT = 3'd5;

  typedef struct packed {
    logic [1:0]                    opcode;
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;
    logic                          last_frame;
    logic [2:0]                    band_select;
    logic [2:0]                    coeff_select;
    logic signed [31:0]            coeff_value;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic                          frame_last;
  } out_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SEL, S_RD, S_WT, S_MUL, S_FIN, S_WR,
    S_GLD, S_GAIN, S_GFIN, S_OUT
  } state_t;

endpackage

// ===== hw/rtl/sbeq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sbeq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hw/rtl/stereo_biquad_cascade_eq.sv =====
// Stereo biquad cascade equalizer, direct form I, one shift-add multiplier.
// Depends on sbeq_pkg and sbeq_ram.
// Each product is formed one multiplier bit per cycle; items are processed one at a time.
// A history clear sweeps every memory address, writing zero history.
// Reset (rst, synchronous) runs the same sweep, loading unit b0 coefficients and
// zero history; no item is accepted during it.
module stereo_biquad_cascade_eq #(
  parameter int BAND_COUNT = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  sbeq_pkg::in_t   in_item,
  output logic            out_valid,
  input  logic            out_stall,
  output sbeq_pkg::out_t  out_item,
  input  logic            cfg_write,
  input  logic [1:0]      cfg_index,
  input  logic [15:0]     cfg_data
);
  import sbeq_pkg::*;

  localparam int BAND_W = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1;
  localparam int AW     = BAND_W + 3;
  localparam int DEPTH  = 2 ** AW;

  localparam logic signed [ACC_W-1:0] SMAX = ACC_W'((64'sd1 <<< (SAMPLE_BITS-1)) - 1);
  localparam logic signed [ACC_W-1:0] SMIN = -SMAX - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] HALF_C = ACC_W'(64'sd1 <<< (FRAC_BITS-1));
  localparam logic signed [ACC_W-1:0] HALF_G = ACC_W'(64'sd1 <<< (GAIN_FRAC-1));
  localparam logic [COEFF_BITS-1:0]   UNIT = COEFF_BITS'(64'd1 << FRAC_BITS);

  function automatic logic signed [SAMPLE_BITS-1:0] sat(input logic signed [ACC_W-1:0] v);
    logic signed [SAMPLE_BITS-1:0] r;
    if (v > SMAX) r = SMAX[SAMPLE_BITS-1:0];
    else if (v < SMIN) r = SMIN[SAMPLE_BITS-1:0];
    else r = v[SAMPLE_BITS-1:0];
    return r;
  endfunction

  state_t state, state_next;

  logic                          eq_enabled;
  logic [7:0]                    band_enable_mask;
  logic [GAIN_BITS-1:0]          output_gain;

  logic [AW-1:0]                 sweep;
  logic                          init_coef;
  logic [BAND_W:0]               band;
  logic                          ch;
  logic [2:0]                    tap;
  logic [CNT_W-1:0]              bitc;
  logic [1:0]                    wr;
  logic signed [ACC_W-1:0]       acc;
  logic signed [ACC_W-1:0]       mcand;
  logic [SAMPLE_BITS-1:0]        mplier;
  logic signed [SAMPLE_BITS-1:0] xcur, h0_old, h2_old, yval;
  logic signed [SAMPLE_BITS-1:0] left_res, right_in;
  logic                          last;

  logic                          accept, band_done, band_on, mul_last, neg, sub_now;
  logic [4:0]                    band_x;
  logic signed [ACC_W-1:0]       shifted;

  logic                          coef_we, hist_we;
  logic [AW-1:0]                 coef_waddr, coef_raddr, hist_waddr, hist_raddr;
  logic [COEFF_BITS-1:0]         coef_wdata, coef_rdata;
  logic [SAMPLE_BITS-1:0]        hist_wdata, hist_rdata;

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign band_done = (32'(band) >= BAND_COUNT);
  assign band_x    = 5'(band);
  assign band_on   = (band_x >= 5'd8) || band_enable_mask[band_x[2:0]];
  assign mul_last  = (state == S_MUL) ? (bitc == CNT_W'(SAMPLE_BITS-1))
                                      : (bitc == CNT_W'(GAIN_BITS-1));
  assign neg       = (state == S_MUL) && (tap >= 3'd3);
  // the sign bit of a sample has negative weight; gain is unsigned
  assign sub_now   = neg ^ ((state == S_MUL) && mul_last);

  always_comb begin
    if (state == S_FIN) shifted = (acc + HALF_C) >>> FRAC_BITS;
    else shifted = (acc + HALF_G) >>> GAIN_FRAC;
  end

  // memories
  assign coef_we    = (state == S_CLEAR && init_coef) ||
                      (accept && in_item.opcode == OP_COEFF &&
                       32'(in_item.band_select) < BAND_COUNT &&
                       in_item.coeff_select < SLOT_LIMIT);
  assign coef_waddr = (state == S_CLEAR) ? sweep
                                         : {BAND_W'(in_item.band_select), in_item.coeff_select};
  assign coef_wdata = (state == S_CLEAR) ? ((sweep[2:0] == 3'd0) ? UNIT : '0)
                                         : COEFF_BITS'(in_item.coeff_value);
  assign coef_raddr = {band[BAND_W-1:0], tap};

  assign hist_we    = (state == S_CLEAR) || (state == S_WR);
  assign hist_waddr = (state == S_CLEAR) ? sweep : {band[BAND_W-1:0], ch, wr};
  always_comb begin
    case (wr)
      2'd0:    hist_wdata = xcur;
      2'd1:    hist_wdata = h0_old;
      2'd2:    hist_wdata = yval;
      default: hist_wdata = h2_old;
    endcase
    if (state == S_CLEAR) hist_wdata = '0;
  end
  assign hist_raddr = {band[BAND_W-1:0], ch, 2'(tap - 3'd1)};

  sbeq_ram #(.WIDTH(COEFF_BITS), .DEPTH(DEPTH)) u_coef (
    .clk, .we(coef_we), .waddr(coef_waddr), .wdata(coef_wdata),
    .raddr(coef_raddr), .rdata(coef_rdata)
  );

  sbeq_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(DEPTH)) u_hist (
    .clk, .we(hist_we), .waddr(hist_waddr), .wdata(hist_wdata),
    .raddr(hist_raddr), .rdata(hist_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (sweep == AW'(DEPTH-1)) state_next = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          case (in_item.opcode)
            OP_FRAME: state_next = eq_enabled ? S_SEL : S_OUT;
            OP_CLEAR: state_next = S_CLEAR;
            default:  state_next = S_IDLE;
          endcase
        end
      end
      S_SEL: begin
        if (band_done) state_next = ch ? S_GLD : S_SEL;
        else if (band_on) state_next = S_RD;
      end
      S_RD:   state_next = S_WT;
      S_WT:   state_next = S_MUL;
      S_MUL:  if (mul_last) state_next = (tap == 3'd4) ? S_FIN : S_RD;
      S_FIN:  state_next = S_WR;
      S_WR:   if (wr == 2'd3) state_next = S_SEL;
      S_GLD:  state_next = S_GAIN;
      S_GAIN: if (mul_last) state_next = S_GFIN;
      S_GFIN: state_next = ch ? S_OUT : S_GLD;
      S_OUT:  if (!out_valid || !out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eq_enabled       <= 1'b1;
      band_enable_mask <= 8'hFF;
      output_gain      <= GAIN_BITS'(4096);
      sweep            <= '0;
      init_coef        <= 1'b1;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (reg_index_t'(cfg_index))
          REG_ENABLE: eq_enabled       <= cfg_data[0];
          REG_MASK:   band_enable_mask <= cfg_data[7:0];
          REG_GAIN:   output_gain      <= cfg_data;
          default:    ;
        endcase
      end

      // load the result register once it is free, else clear valid once the receiver takes the item
      if (state == S_OUT && (!out_valid || !out_stall)) begin
        out_valid           <= 1'b1;
        out_item.left_out   <= left_res;
        out_item.right_out  <= right_in;
        out_item.frame_last <= last;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_CLEAR: begin
          sweep <= sweep + AW'(1);
          if (sweep == AW'(DEPTH-1)) init_coef <= 1'b0;
        end
        S_IDLE: begin
          if (accept) begin
            xcur     <= in_item.left_sample;
            left_res <= in_item.left_sample;
            right_in <= in_item.right_sample;
            last     <= in_item.last_frame;
            band     <= '0;
            ch       <= 1'b0;
            tap      <= '0;
            sweep    <= '0;
          end
        end
        S_SEL: begin
          if (band_done) begin
            // left cascade done: hold its result, start right channel
            if (!ch) begin
              left_res <= xcur;
              xcur     <= right_in;
              band     <= '0;
              ch       <= 1'b1;
            end else begin
              ch <= 1'b0;
            end
          end else if (band_on) begin
            tap <= '0;
            acc <= '0;
          end else begin
            band <= band + (BAND_W+1)'(1);
          end
        end
        S_WT: begin
          mcand <= ACC_W'($signed(coef_rdata));
          mplier <= (tap == 3'd0) ? xcur : hist_rdata;
          bitc  <= '0;
          if (tap == 3'd1) h0_old <= hist_rdata;
          if (tap == 3'd3) h2_old <= hist_rdata;
        end
        S_MUL, S_GAIN: begin
          if (mplier[0]) acc <= sub_now ? acc - mcand : acc + mcand;
          mcand  <= mcand <<< 1;
          mplier <= mplier >> 1;
          bitc   <= bitc + CNT_W'(1);
          if (state == S_MUL && mul_last) tap <= tap + 3'd1;
        end
        S_FIN: begin
          yval <= sat(shifted);
          wr   <= '0;
        end
        S_WR: begin
          wr <= wr + 2'd1;
          if (wr == 2'd3) begin
            xcur <= yval;
            band <= band + (BAND_W+1)'(1);
          end
        end
        S_GLD: begin
          acc    <= '0;
          mcand  <= ch ? ACC_W'(xcur) : ACC_W'(left_res);
          mplier <= SAMPLE_BITS'(output_gain);
          bitc   <= '0;
        end
        S_GFIN: begin
          if (ch) right_in <= sat(shifted);
          else left_res <= sat(shifted);
          ch <= ~ch;
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for stereo_biquad_cascade_eq: directed table, then random phases.
// Depends on sbeq_pkg and the equalizer RTL; predicts the filter cascade in SystemVerilog.
module tb_top;
  import sbeq_pkg::*;

  localparam int NBANDS = 8;
  localparam int WATCH_LIMIT = 20000;
  localparam int HOLD_CYCLES = 4000;
  localparam int DRAIN_CYCLES = 150;
  localparam int IN_W = $bits(in_t);
  localparam longint SMAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint SMIN = -SMAX - 1;

  typedef struct {
    in_t  item;
    bit   typed;
    out_t want;
  } row_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_t in_item;
  logic out_valid;
  logic out_stall;
  out_t out_item;
  logic cfg_write;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data;

  longint coef_mem[NBANDS][5];
  longint hist_mem[NBANDS][2][4];
  bit eq_on;
  logic [7:0] band_mask;
  logic [15:0] gain_q12;

  out_t pending_frames[$];
  int error_count;
  bit hold_req;
  bit quiet;
  row_t rows[16];

  stereo_biquad_cascade_eq i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint clamp_sample(longint v);
    if (v > SMAX) return SMAX;
    if (v < SMIN) return SMIN;
    return v;
  endfunction

  // Direct form I section; sum of exact products, round half up, saturate.
  function automatic longint biquad_section(int b, int ch, longint x);
    longint acc;
    longint y;
    acc = coef_mem[b][0] * x + coef_mem[b][1] * hist_mem[b][ch][0]
        + coef_mem[b][2] * hist_mem[b][ch][1] - coef_mem[b][3] * hist_mem[b][ch][2]
        - coef_mem[b][4] * hist_mem[b][ch][3];
    y = clamp_sample((acc + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
    hist_mem[b][ch][1] = hist_mem[b][ch][0];
    hist_mem[b][ch][0] = x;
    hist_mem[b][ch][3] = hist_mem[b][ch][2];
    hist_mem[b][ch][2] = y;
    return y;
  endfunction

  function automatic void reset_model();
    for (int b = 0; b < NBANDS; b++) begin
      for (int k = 0; k < 5; k++) coef_mem[b][k] = 0;
      coef_mem[b][0] = 64'sd1 <<< FRAC_BITS;
      for (int c = 0; c < 2; c++)
        for (int k = 0; k < 4; k++) hist_mem[b][c][k] = 0;
    end
    eq_on = 1'b1;
    band_mask = 8'hff;
    gain_q12 = 16'd4096;
  endfunction

  // Update the model for one item; return 1 with the expected frame if one is due.
  function automatic bit equalize(in_t it, output out_t res);
    longint l;
    longint r;
    longint g;
    res = '0;
    if (it.opcode == OP_COEFF) begin
      if (it.coeff_select < SLOT_LIMIT)
        coef_mem[it.band_select][it.coeff_select] = longint'(it.coeff_value);
      return 1'b0;
    end
    if (it.opcode == OP_CLEAR) begin
      for (int b = 0; b < NBANDS; b++)
        for (int c = 0; c < 2; c++)
          for (int k = 0; k < 4; k++) hist_mem[b][c][k] = 0;
      return 1'b0;
    end
    if (it.opcode != OP_FRAME) return 1'b0;
    l = longint'(it.left_sample);
    r = longint'(it.right_sample);
    if (eq_on) begin
      for (int b = 0; b < NBANDS; b++)
        if (band_mask[b]) begin
          l = biquad_section(b, 0, l);
          r = biquad_section(b, 1, r);
        end
      g = longint'(gain_q12);
      l = clamp_sample((l * g + (64'sd1 <<< (GAIN_FRAC - 1))) >>> GAIN_FRAC);
      r = clamp_sample((r * g + (64'sd1 <<< (GAIN_FRAC - 1))) >>> GAIN_FRAC);
    end
    res.left_out = l[SAMPLE_BITS-1:0];
    res.right_out = r[SAMPLE_BITS-1:0];
    res.frame_last = it.last_frame;
    return 1'b1;
  endfunction

  function automatic in_t frame_item(int l, int r, bit last);
    in_t it;
    it = in_t'(IN_W'({$urandom, $urandom, $urandom}));
    it.opcode = OP_FRAME;
    it.left_sample = l[SAMPLE_BITS-1:0];
    it.right_sample = r[SAMPLE_BITS-1:0];
    it.last_frame = last;
    return it;
  endfunction

  function automatic in_t coeff_item(int band, int slot, int val);
    in_t it;
    it = in_t'(IN_W'({$urandom, $urandom, $urandom}));
    it.opcode = OP_COEFF;
    it.band_select = band[2:0];
    it.coeff_select = slot[2:0];
    it.coeff_value = val;
    return it;
  endfunction

  function automatic in_t op_item(opcode_t op);
    in_t it;
    it = in_t'(IN_W'({$urandom, $urandom, $urandom}));
    it.opcode = op;
    return it;
  endfunction

  task automatic report(string field, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", field, got, want);
    error_count++;
  endtask

  // Offer one item and hold it until accepted.
  task automatic send_item(in_t it, bit typed, out_t want);
    out_t pred;
    bit has;
    in_item <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    has = equalize(it, pred);
    if (has) pending_frames.push_back(typed ? want : pred);
  endtask

  task automatic go_idle(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, int val);
    go_idle(0);
    wait (pending_frames.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[15:0];
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_ENABLE: eq_on = val[0];
      REG_MASK: band_mask = val[7:0];
      REG_GAIN: gain_q12 = val[15:0];
      default: ;
    endcase
  endtask

  function automatic in_t random_item();
    int pick;
    int cval;
    pick = $urandom_range(0, 99);
    if (pick < 60)
      return frame_item(int'($urandom), int'($urandom), 1'($urandom_range(0, 1)));
    if (pick < 88) begin
      // Half of the time, tame coefficients (within +/-0.5) to keep the cascade out of saturation.
      if ($urandom_range(0, 1)) cval = int'($urandom_range(0, 1 << 29)) - (1 << 28);
      else cval = int'($urandom);
      return coeff_item($urandom_range(0, 7), $urandom_range(0, 7), cval);
    end
    if (pick < 95) return op_item(OP_CLEAR);
    return op_item(OP_NONE);
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_frames.size() == 0) begin
        report("unexpected frame left_out", out_item.left_out, 0);
      end else begin
        if (out_item.left_out !== pending_frames[0].left_out)
          report("left_out", out_item.left_out, pending_frames[0].left_out);
        if (out_item.right_out !== pending_frames[0].right_out)
          report("right_out", out_item.right_out, pending_frames[0].right_out);
        if (out_item.frame_last !== pending_frames[0].frame_last)
          report("frame_last", out_item.frame_last, pending_frames[0].frame_last);
        void'(pending_frames.pop_front());
      end
    end
  end

  // Receiver stalls: one long hold on request, else random bursts unless quiet.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCH_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    out_t want;
    in_t it;
    int nrows;
    error_count = 0;
    hold_req = 1'b0;
    quiet = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    cfg_write = 1'b0;
    cfg_index = REG_ENABLE;
    cfg_data = '0;
    reset_model();

    rows[0] = '{frame_item(int'(SMAX), int'(SMAX), 1'b1), 1'b1,
                '{SAMPLE_BITS'(SMAX), SAMPLE_BITS'(SMAX), 1'b1}};
    rows[1] = '{frame_item(int'(SMIN), int'(SMIN), 1'b0), 1'b1,
                '{SAMPLE_BITS'(SMIN), SAMPLE_BITS'(SMIN), 1'b0}};
    rows[2] = '{frame_item(0, -1, 1'b0), 1'b1, '{24'sd0, -24'sd1, 1'b0}};
    rows[3] = '{op_item(OP_NONE), 1'b0, '0};
    rows[4] = '{coeff_item(0, 1, 32'h2000_0000), 1'b0, '0};
    rows[5] = '{frame_item(1000, -1000, 1'b0), 1'b0, '0};
    rows[6] = '{coeff_item(7, 3, 32'h8000_0000), 1'b0, '0};
    rows[7] = '{coeff_item(3, 4, 32'h7fff_ffff), 1'b0, '0};
    rows[8] = '{coeff_item(2, 5, 32'h1234_5678), 1'b0, '0};
    rows[9] = '{coeff_item(2, 7, 32'hffff_ffff), 1'b0, '0};
    rows[10] = '{frame_item(int'(SMAX), int'(SMIN), 1'b1), 1'b0, '0};
    rows[11] = '{op_item(OP_CLEAR), 1'b0, '0};
    rows[12] = '{frame_item(12345, -54321, 1'b0), 1'b0, '0};
    rows[13] = '{coeff_item(7, 3, 0), 1'b0, '0};
    rows[14] = '{coeff_item(3, 4, 0), 1'b0, '0};
    rows[15] = '{frame_item(-777, 4242, 1'b1), 1'b0, '0};
    nrows = 16;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < nrows; i++) begin
      send_item(rows[i].item, rows[i].typed, rows[i].want);
      if ($urandom_range(0, 2) == 0) go_idle($urandom_range(1, 14));
    end

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_GAIN, 4096);
        end
        1: begin
          write_reg(REG_ENABLE, 0);
        end
        2: begin
          write_reg(REG_ENABLE, 1);
          write_reg(REG_MASK, 0);
          write_reg(REG_GAIN, 65535);
        end
        3: begin
          write_reg(REG_MASK, $urandom_range(0, 255));
          write_reg(REG_GAIN, 0);
        end
        default: begin
          write_reg(REG_MASK, 8'hff);
          write_reg(REG_GAIN, $urandom_range(0, 8192));
          quiet = 1'b1;
        end
      endcase
      for (int n = 0; n < 100; ) begin
        if (phase == 1 && n == 30) hold_req = 1'b1;
        if (phase == 2 && n == 40) begin
          go_idle(0);
          wait (pending_frames.size() == 0);
        end
        it = random_item();
        send_item(it, 1'b0, want);
        if (it.opcode != OP_NONE) n++;
        if (!quiet && $urandom_range(0, 3) == 0) go_idle($urandom_range(1, 14));
      end
    end

    go_idle(0);
    wait (pending_frames.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/sbeq_pkg.sv
hw/rtl/sbeq_ram.sv
hw/rtl/stereo_biquad_cascade_eq.sv
verif/tb_top.sv
